// ----- sv/vgapm_pkg.sv -----
// shared types, register codes and helper functions for the planar vga memory
// no dependencies; imported by vgapm_write_path and vga_planar_memory_access

package vgapm_pkg;

  // default plane address width and fixed field widths
  localparam int unsigned PLANE_ADDR_BITS_DEF = 16;
  localparam int unsigned CPU_ADDR_W          = 16;
  localparam int unsigned BYTE_W              = 8;
  localparam int unsigned NUM_PLANES          = 4;
  localparam int unsigned WORD_W              = BYTE_W * NUM_PLANES;
  localparam int unsigned CFG_IDX_W           = 3;

  // bit positions inside mode_flags
  localparam int unsigned MF_ENABLE   = 0;
  localparam int unsigned MF_CHAIN4   = 1;
  localparam int unsigned MF_ODD_EVEN = 2;
  localparam int unsigned MF_CHAIN_OE = 3;
  localparam int unsigned MF_COMPARE  = 4;

  // address bits used by chain-4 and chain odd/even
  localparam int unsigned CHAIN4_LO_SRC = 14;
  localparam int unsigned CHAIN4_HI_SRC = 15;

  localparam logic [BYTE_W-1:0] DISABLED_READ = 8'hFF;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE_FLAGS      = 3'd0,
    REG_PLANE_WRITE_MSK = 3'd1,
    REG_READ_PLANE      = 3'd2,
    REG_COLOR_COMPARE   = 3'd3,
    REG_WRITE_CONTROL   = 3'd4,
    REG_SET_RESET       = 3'd5,
    REG_BIT_MASK        = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    WMODE_ROTATE = 2'd0,
    WMODE_LATCH  = 2'd1,
    WMODE_EXPAND = 2'd2,
    WMODE_MASKED = 2'd3
  } write_mode_t;

  typedef enum logic [1:0] {
    ALU_PASS = 2'd0,
    ALU_AND  = 2'd1,
    ALU_OR   = 2'd2,
    ALU_XOR  = 2'd3
  } alu_op_t;

  // register file contents
  typedef struct packed {
    logic [4:0] mode_flags;
    logic [3:0] plane_write_mask;
    logic [1:0] read_plane;
    logic [7:0] color_compare_care;
    logic [6:0] write_control;
    logic [7:0] set_reset_control;
    logic [7:0] bit_mask;
  } vgapm_cfg_t;

  // rotate a byte right
  function automatic logic [BYTE_W-1:0] ror8(input logic [BYTE_W-1:0] b,
                                             input logic [2:0] n);
    logic [2*BYTE_W-1:0] dbl;
    begin
      dbl  = {b, b} >> n;
      ror8 = dbl[BYTE_W-1:0];
    end
  endfunction

  // colour compare over the planes that take part
  function automatic logic [BYTE_W-1:0] color_compare(input logic [WORD_W-1:0] word,
                                                      input logic [7:0] care);
    logic [BYTE_W-1:0] res;
    begin
      res = DISABLED_READ;
      for (int k = 0; k < NUM_PLANES; k++) begin
        if (care[4+k]) begin
          res = res & ~(word[BYTE_W*k +: BYTE_W] ^ {BYTE_W{care[k]}});
        end
      end
      color_compare = res;
    end
  endfunction

endpackage

// ----- sv/vgapm_write_path.sv -----
// write datapath: write modes, alu and bit mask for all four planes side by side
// depends on vgapm_pkg

module vgapm_write_path (
  input  vgapm_pkg::vgapm_cfg_t        cfg,
  input  logic [vgapm_pkg::WORD_W-1:0] latches,
  input  logic [vgapm_pkg::BYTE_W-1:0] data,
  output logic [vgapm_pkg::WORD_W-1:0] word
);
  import vgapm_pkg::*;

  write_mode_t       wmode;
  alu_op_t           alu;
  logic [BYTE_W-1:0] rotated;
  logic [BYTE_W-1:0] mask;

  // decode write control
  assign wmode   = write_mode_t'(cfg.write_control[1:0]);
  assign alu     = alu_op_t'(cfg.write_control[3:2]);
  assign rotated = ror8(data, cfg.write_control[6:4]);
  assign mask    = (wmode == WMODE_MASKED) ? (cfg.bit_mask & rotated) : cfg.bit_mask;

  // per-plane byte build
  always_comb begin
    logic [BYTE_W-1:0] lat;
    logic [BYTE_W-1:0] src;
    logic [BYTE_W-1:0] res;
    word = '0;
    for (int k = 0; k < NUM_PLANES; k++) begin
      lat = latches[BYTE_W*k +: BYTE_W];
      if (wmode == WMODE_EXPAND) begin
        src = {BYTE_W{data[k]}};
      end else if (wmode == WMODE_MASKED || cfg.set_reset_control[4+k]) begin
        src = {BYTE_W{cfg.set_reset_control[k]}};
      end else begin
        src = rotated;
      end
      case (alu)
        ALU_AND: res = src & lat;
        ALU_OR:  res = src | lat;
        ALU_XOR: res = src ^ lat;
        default: res = src;
      endcase
      if (wmode == WMODE_LATCH) begin
        word[BYTE_W*k +: BYTE_W] = lat;
      end else begin
        word[BYTE_W*k +: BYTE_W] = lat ^ ((res ^ lat) & mask);
      end
    end
  end

endmodule

// ----- sv/vga_planar_memory_access.sv -----
// top level: four-plane display memory, data latches, address mapping and registers
// depends on vgapm_pkg and vgapm_write_path
//
// After reset the block clears its whole display memory, one word a cycle, with
// busy high; register writes are taken during that time. A write access leaves
// busy low, and the next access can start in the following cycle. An enabled
// read goes through the registered plane memory output: busy is high for the
// cycle after start, and read_data is registered from that output together
// with done. A read while the block is disabled returns 0xFF with done in the
// cycle after start. done lasts one cycle and cannot be held off, so the
// receiver must take read_data in that cycle. Register writes are always
// ready and should be issued only while no access is outstanding.

module vga_planar_memory_access #(
  parameter int unsigned PLANE_ADDR_BITS = vgapm_pkg::PLANE_ADDR_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // access command
  input  logic                              start,
  output logic                              busy,
  input  logic                              command,
  input  logic [vgapm_pkg::CPU_ADDR_W-1:0]  address,
  input  logic [vgapm_pkg::BYTE_W-1:0]      write_data,
  // read result
  output logic                              done,
  output logic [vgapm_pkg::BYTE_W-1:0]      read_data,
  // register write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [vgapm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vgapm_pkg::BYTE_W-1:0]      cfg_data
);
  import vgapm_pkg::*;

  localparam int unsigned WORDS = 1 << PLANE_ADDR_BITS;

  // display memory, byte k of a word is plane k
  logic [WORD_W-1:0] mem [WORDS];
  logic [WORD_W-1:0] mem_q;

  vgapm_cfg_t                 cfg;
  logic [WORD_W-1:0]          latches;
  logic                       clearing;
  logic [PLANE_ADDR_BITS-1:0] clr_addr;
  logic                       rd_pending;

  logic                       accept;
  logic                       enabled;
  logic [CPU_ADDR_W-1:0]      map_addr;
  logic [1:0]                 rd_plane;
  logic [NUM_PLANES-1:0]      wr_planes;
  logic [WORD_W-1:0]          wr_word;

  logic                       mem_we;
  logic [PLANE_ADDR_BITS-1:0] mem_waddr;
  logic [WORD_W-1:0]          mem_wdata;
  logic [NUM_PLANES-1:0]      mem_be;

  assign cfg_ready = 1'b1;
  assign busy      = clearing | rd_pending;
  assign accept    = start & ~busy;
  assign enabled   = cfg.mode_flags[MF_ENABLE];

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode_flags         <= '0;
      cfg.plane_write_mask   <= '1;
      cfg.read_plane         <= '0;
      cfg.color_compare_care <= '0;
      cfg.write_control      <= '0;
      cfg.set_reset_control  <= '0;
      cfg.bit_mask           <= '1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_MODE_FLAGS:      cfg.mode_flags         <= cfg_data[4:0];
        REG_PLANE_WRITE_MSK: cfg.plane_write_mask   <= cfg_data[3:0];
        REG_READ_PLANE:      cfg.read_plane         <= cfg_data[1:0];
        REG_COLOR_COMPARE:   cfg.color_compare_care <= cfg_data;
        REG_WRITE_CONTROL:   cfg.write_control      <= cfg_data[6:0];
        REG_SET_RESET:       cfg.set_reset_control  <= cfg_data;
        REG_BIT_MASK:        cfg.bit_mask           <= cfg_data;
        default: ;
      endcase
    end
  end

  // address mapping, read plane and write plane mask
  always_comb begin
    map_addr  = address;
    rd_plane  = cfg.read_plane;
    wr_planes = cfg.plane_write_mask;
    if (cfg.mode_flags[MF_CHAIN4]) begin
      rd_plane    = address[1:0];
      wr_planes   = cfg.plane_write_mask & (NUM_PLANES'(1) << address[1:0]);
      map_addr[0] = address[CHAIN4_LO_SRC];
      map_addr[1] = address[CHAIN4_HI_SRC];
    end else if (cfg.mode_flags[MF_ODD_EVEN]) begin
      rd_plane[0] = address[0];
      wr_planes   = cfg.plane_write_mask & (address[0] ? 4'b1010 : 4'b0101);
      if (command) begin
        map_addr[0] = 1'b0;
      end
    end
    if (cfg.mode_flags[MF_CHAIN_OE]) begin
      map_addr[0] = address[CHAIN4_HI_SRC];
    end
  end

  vgapm_write_path u_write_path (
    .cfg     (cfg),
    .latches (latches),
    .data    (write_data),
    .word    (wr_word)
  );

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (&clr_addr) begin
        clearing <= 1'b0;
      end
    end
  end

  // memory write port select
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = map_addr[PLANE_ADDR_BITS-1:0];
    mem_wdata = wr_word;
    mem_be    = wr_planes;
    if (clearing) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
      mem_be    = '1;
    end else if (accept && command && enabled) begin
      mem_we = 1'b1;
    end
  end

  // memory write with per-plane enables
  always_ff @(posedge clk) begin
    if (mem_we) begin
      for (int k = 0; k < NUM_PLANES; k++) begin
        if (mem_be[k]) begin
          mem[mem_waddr][BYTE_W*k +: BYTE_W] <= mem_wdata[BYTE_W*k +: BYTE_W];
        end
      end
    end
  end

  // memory read, registered
  always_ff @(posedge clk) begin
    mem_q <= mem[map_addr[PLANE_ADDR_BITS-1:0]];
  end

  // read tracking and read plane hold
  logic [1:0] rd_plane_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
    end else begin
      rd_pending <= accept & ~command & enabled;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_plane_q <= rd_plane;
    end
  end

  // latches load on every enabled read
  always_ff @(posedge clk) begin
    if (rst) begin
      latches <= '0;
    end else if (rd_pending) begin
      latches <= mem_q;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= rd_pending | (accept & ~command & ~enabled);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pending) begin
      if (cfg.mode_flags[MF_COMPARE]) begin
        read_data <= color_compare(mem_q, cfg.color_compare_care);
      end else begin
        read_data <= mem_q[BYTE_W*rd_plane_q +: BYTE_W];
      end
    end else if (accept) begin
      read_data <= DISABLED_READ;
    end
  end

  // checks
  a_no_done_while_clearing: assert property (
    @(posedge clk) disable iff (rst) clearing |-> !done)
    else $error("result word during clearing pass");

  a_read_gives_word: assert property (
    @(posedge clk) disable iff (rst) rd_pending |=> done)
    else $error("enabled read lost its result word");

  a_read_holds_busy: assert property (
    @(posedge clk) disable iff (rst) (accept && !command && enabled) |=> busy)
    else $error("enabled read did not hold busy");

  a_no_write_on_read: assert property (
    @(posedge clk) disable iff (rst) rd_pending |-> !mem_we)
    else $error("memory write while read outstanding");

endmodule
